@@ sv/string_literal_unescaper_unit_macros.svh @@
// Assertion macros used by the checker of the string literal unescaper.
`ifndef STRING_LITERAL_UNESCAPER_UNIT_MACROS_SVH
`define STRING_LITERAL_UNESCAPER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/slu_pkg.sv @@
// Types and constants shared by the string literal unescaper modules.
`timescale 1ns / 1ps

package slu_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_DATA      = 3'd0;
    localparam logic [2:0] KIND_CLOSED    = 3'd1;
    localparam logic [2:0] KIND_UNTERM    = 3'd2;
    localparam logic [2:0] KIND_NEWLINE   = 3'd3;
    localparam logic [2:0] KIND_BACKSLASH = 3'd4;
    localparam logic [2:0] KIND_BADU      = 3'd5;

    localparam int MAX_RESULTS = 3;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LIT  = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HEX  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       source_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] result_kind;
        logic       last_of_run;
    } out_item_t;

    // Decoder state; three hex digits are held, the fourth completes the code point.
    typedef struct packed {
        phase_t      phase;
        logic        quote_single;
        logic [11:0] hex_acc;
        logic [1:0]  hex_seen;
    } dec_state_t;

    typedef struct packed {
        logic [1:0]                        count;
        out_item_t [MAX_RESULTS-1:0]       res;
    } dec_result_t;

endpackage

@@ sv/slu_decode.sv @@
// Combinational decoder: one source byte and the current state to results and next state.
`timescale 1ns / 1ps

module slu_decode
    import slu_pkg::*;
(
    input  dec_state_t  state,
    input  in_item_t    item,
    output dec_state_t  state_next,
    output dec_result_t result
);

    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [5:0] UTF8_MASK  = 6'h3F;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic out_item_t mk(input logic [7:0] b, input logic [2:0] kind,
                                     input logic last);
        out_item_t r;
        r.out_byte    = b;
        r.result_kind = kind;
        r.last_of_run = last;
        return r;
    endfunction

    logic [7:0]  b;
    logic        src_end;
    logic [7:0]  quote_ch;
    logic [4:0]  digit;
    logic [15:0] cp;
    logic [7:0]  esc_val;

    assign b        = item.in_byte;
    assign src_end  = item.source_end;
    assign quote_ch = state.quote_single ? CH_SQUOTE : CH_DQUOTE;
    assign digit    = hex_digit(b);
    assign cp       = {state.hex_acc, digit[3:0]};

    always_comb
    begin
        case (b)
            CH_LOWER_N: esc_val = CH_NEWLINE;
            CH_LOWER_T: esc_val = CH_TAB;
            CH_LOWER_R: esc_val = CH_CR;
            CH_ZERO:    esc_val = CH_NUL;
            default:    esc_val = b;
        endcase
    end

    always_comb
    begin
        state_next   = state;
        result.count = 2'd0;
        result.res   = '0;

        unique case (state.phase)
            PH_IDLE:
            begin
                if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                    state_next.quote_single = (b == CH_SQUOTE);
                    if (src_end) begin
                        result.count  = 2'd1;
                        result.res[0] = mk(8'h00, KIND_UNTERM, 1'b1);
                    end
                    else begin
                        state_next.phase = PH_LIT;
                    end
                end
            end
            PH_LIT:
            begin
                if (b == CH_BACKSLASH) begin
                    if (src_end) begin
                        result.count  = 2'd1;
                        result.res[0] = mk(8'h00, KIND_BACKSLASH, 1'b1);
                    end
                    else begin
                        state_next.phase = PH_ESC;
                    end
                end
                else if (b == quote_ch) begin
                    result.count     = 2'd1;
                    result.res[0]    = mk(8'h00, KIND_CLOSED, 1'b1);
                    state_next.phase = PH_IDLE;
                end
                else if (b == CH_NEWLINE) begin
                    result.count     = 2'd1;
                    result.res[0]    = mk(8'h00, KIND_NEWLINE, 1'b1);
                    state_next.phase = PH_IDLE;
                end
                else if (src_end) begin
                    result.count  = 2'd1;
                    result.res[0] = mk(8'h00, KIND_UNTERM, 1'b1);
                end
                else begin
                    result.count  = 2'd1;
                    result.res[0] = mk(b, KIND_DATA, 1'b1);
                end
            end
            PH_ESC:
            begin
                if (src_end) begin
                    result.count  = 2'd1;
                    result.res[0] = mk(8'h00, (b == CH_LOWER_U) ? KIND_BADU : KIND_UNTERM,
                                       1'b1);
                end
                else if (b == CH_LOWER_U) begin
                    state_next.phase    = PH_HEX;
                    state_next.hex_acc  = '0;
                    state_next.hex_seen = '0;
                end
                else begin
                    result.count     = 2'd1;
                    result.res[0]    = mk(esc_val, KIND_DATA, 1'b1);
                    state_next.phase = PH_LIT;
                end
            end
            PH_HEX:
            begin
                if (!digit[4]) begin
                    result.count     = 2'd1;
                    result.res[0]    = mk(8'h00, KIND_BADU, 1'b1);
                    state_next.phase = PH_IDLE;
                end
                else if (state.hex_seen == 2'd3) begin
                    state_next.hex_acc  = '0;
                    state_next.hex_seen = '0;
                    if (src_end) begin
                        result.count  = 2'd1;
                        result.res[0] = mk(8'h00, KIND_UNTERM, 1'b1);
                    end
                    else begin
                        state_next.phase = PH_LIT;
                        if (cp < 16'h0080) begin
                            result.count  = 2'd1;
                            result.res[0] = mk({1'b0, cp[6:0]}, KIND_DATA, 1'b1);
                        end
                        else if (cp < 16'h0800) begin
                            result.count  = 2'd2;
                            result.res[0] = mk(UTF8_LEAD2 | {3'b000, cp[10:6]}, KIND_DATA, 1'b0);
                            result.res[1] = mk(UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK},
                                               KIND_DATA, 1'b1);
                        end
                        else begin
                            result.count  = 2'd3;
                            result.res[0] = mk(UTF8_LEAD3 | {4'b0000, cp[15:12]}, KIND_DATA,
                                               1'b0);
                            result.res[1] = mk(UTF8_CONT | {2'b00, cp[11:6] & UTF8_MASK},
                                               KIND_DATA, 1'b0);
                            result.res[2] = mk(UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK},
                                               KIND_DATA, 1'b1);
                        end
                    end
                end
                else begin
                    state_next.hex_acc  = cp[11:0];
                    state_next.hex_seen = state.hex_seen + 2'd1;
                    if (src_end) begin
                        result.count  = 2'd1;
                        result.res[0] = mk(8'h00, KIND_BADU, 1'b1);
                    end
                end
            end
            default:
            begin
                state_next.phase = PH_IDLE;
            end
        endcase

        // The end of the source always leaves the block idle.
        if (src_end) begin
            state_next.phase    = PH_IDLE;
            state_next.hex_acc  = '0;
            state_next.hex_seen = '0;
        end
    end

endmodule

@@ sv/string_literal_unescaper_unit.sv @@
// String literal unescaper: C-style escapes and \u code points decoded to UTF-8 bytes.
// Usage:
//   Source bytes enter on src_valid/src_ready with src_item (in_byte, source_end).
//   Decoded items leave on res_valid/res_ready with res_item (out_byte, result_kind,
//   last_of_run); each source byte yields zero to three result items.
// Latency: the first result of a byte is shown in the cycle after it is accepted.
// Throughput: one source byte per cycle while each byte yields at most one result
//   and the receiver takes every item. A \u escape that gives two or three UTF-8
//   bytes holds src_ready low while the three-entry result buffer drains, one item
//   per cycle through its output port while res_ready is high.
// Reset: the decoder returns to idle (outside any literal) and the result buffer
//   empties; no item is shown until a byte has been accepted.
// Stalls: while res_ready is low the shown item holds, and src_ready stays high
//   only if the buffer will be free by the end of the cycle, so no item is lost.
`timescale 1ns / 1ps

module string_literal_unescaper_unit
    import slu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  in_item_t  src_item,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res_item
);

    dec_state_t                  state_reg;
    dec_state_t                  state_next;
    dec_result_t                 dec_res;
    out_item_t [MAX_RESULTS-1:0] slot_reg;
    out_item_t [MAX_RESULTS-1:0] slot_next;
    logic [1:0]                  rem_reg;
    logic [1:0]                  rem_next;
    logic                        accept;
    logic                        take;

    slu_decode u_decode (
        .state      (state_reg),
        .item       (src_item),
        .state_next (state_next),
        .result     (dec_res)
    );

    assign res_valid = (rem_reg != 2'd0);
    assign res_item  = slot_reg[0];
    assign take      = res_valid && res_ready;
    assign src_ready = (rem_reg == 2'd0) || (rem_reg == 2'd1 && res_ready);
    assign accept    = src_valid && src_ready;

    // New results are loaded only when the buffer empties in this cycle.
    always_comb
    begin
        slot_next = slot_reg;
        rem_next  = rem_reg;
        if (accept && dec_res.count != 2'd0) begin
            slot_next = dec_res.res;
            rem_next  = dec_res.count;
        end
        else if (take) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            rem_next     = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.phase        <= PH_IDLE;
            state_reg.quote_single <= 1'b0;
            state_reg.hex_acc      <= '0;
            state_reg.hex_seen     <= '0;
            rem_reg                <= 2'd0;
        end
        else begin
            if (accept) begin
                state_reg <= state_next;
            end
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

@@ sv/slu_checker.sv @@
// Port-level checker for the string literal unescaper, bound to the top level.
`timescale 1ns / 1ps
`include "string_literal_unescaper_unit_macros.svh"

module slu_checker
    import slu_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      src_valid,
    input logic      src_ready,
    input in_item_t  src_item,
    input logic      res_valid,
    input logic      res_ready,
    input out_item_t res_item
);

    `SLU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_item), "result item changed while stalled")
    `SLU_ASSERT_NOW(a_kind_legal, res_valid, res_item.result_kind <= KIND_BADU, "result kind out of range")
    `SLU_ASSERT_NOW(a_status_zero, res_valid && res_item.result_kind != KIND_DATA, res_item.out_byte == 8'h00, "status item carries a non-zero byte")
    `SLU_ASSERT_NOW(a_status_last, res_valid && res_item.result_kind != KIND_DATA, res_item.last_of_run, "status item is not the last of its run")

endmodule

bind string_literal_unescaper_unit slu_checker u_slu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
);
